### rtl/spd_pkg.sv
// Shared constants, types and saturation helpers for the stereo ping-pong delay.
// Depends on nothing; every other file of the block imports it.
package spd_pkg;

   // Store geometry and sample width (depth must be a power of two)
   localparam int STORE_DEPTH = 65536;
   localparam int SAMPLE_BITS = 24;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Port field and register widths
   localparam int FIELD_W    = 24;
   localparam int BAL_W      = 16;
   localparam int DLY_W      = 24;
   localparam int FB_W       = 16;
   localparam int MIX_W      = 17;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int FRAC_W     = 8;

   // Datapath widths: working values, gain operand, product, read position
   localparam int MAX_W  = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
   localparam int VAL_W  = MAX_W + 4;
   localparam int GAIN_W = 17;
   localparam int PROD_W = VAL_W + GAIN_W + 1;
   localparam int RP_W   = ADDR_W + FRAC_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BALANCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX      = 2'd3;

   // Register reset values
   localparam logic [BAL_W-1:0] BAL_RESET = 16'd16384;
   localparam logic [DLY_W-1:0] DLY_RESET = 24'd1228800;
   localparam logic [FB_W-1:0]  FB_RESET  = 16'd45875;
   localparam logic [MIX_W-1:0] MIX_RESET = 17'd65536;

   localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);

   localparam logic signed [VAL_W-1:0] SMP_MAX =
      VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [VAL_W-1:0] SMP_MIN = -SMP_MAX - VAL_W'(1);
   localparam logic signed [VAL_W-1:0] FLD_MAX =
      VAL_W'((64'sd1 <<< (FIELD_W - 1)) - 64'sd1);
   localparam logic signed [VAL_W-1:0] FLD_MIN = -FLD_MAX - VAL_W'(1);

   // One multiply request to the shared unit
   typedef struct packed {
      logic [GAIN_W-1:0] op_a;     // unsigned gain or fraction
      logic [VAL_W-1:0]  op_b;     // signed sample value
      logic              shift16;  // scale by 2^16, else by 2^8
   } mul_issue_type;

   // Clamp a working value to the signed sample range
   function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] c;
      c = v;
      if (v > SMP_MAX) c = SMP_MAX;
      if (v < SMP_MIN) c = SMP_MIN;
      return c[SAMPLE_BITS-1:0];
   endfunction

   // Clamp a sample to the port field range
   function automatic logic [FIELD_W-1:0] to_field(input logic [SAMPLE_BITS-1:0] s);
      logic signed [VAL_W-1:0] v;
      logic signed [VAL_W-1:0] c;
      v = {{(VAL_W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
      c = v;
      if (v > FLD_MAX) c = FLD_MAX;
      if (v < FLD_MIN) c = FLD_MIN;
      return c[FIELD_W-1:0];
   endfunction

endpackage

### rtl/spd_req_if.sv
// Input stream interface: one stereo sample pair per transaction.
// Depends on spd_pkg for the field width.
interface spd_req_if import spd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] left_in;
   logic signed [FIELD_W-1:0] right_in;

   modport source (output valid, left_in, right_in, input ready);
   modport sink   (input valid, left_in, right_in, output ready);
endinterface

### rtl/spd_rsp_if.sv
// Result stream interface: one processed stereo pair per transaction.
// Depends on spd_pkg for the field width.
interface spd_rsp_if import spd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] left_out;
   logic signed [FIELD_W-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

### rtl/spd_mul.sv
// Shared multiply, round and accumulate unit: product registered, then
// rounded half up by 2^8 or 2^16 and added to an accumulator. Uses spd_pkg.
module spd_mul import spd_pkg::*; (
   input  logic                    clock,
   input  mul_issue_type           issue,
   input  logic signed [VAL_W-1:0] acc,
   output logic signed [VAL_W-1:0] result
);

   localparam logic signed [PROD_W-1:0] HALF8  = PROD_W'(128);
   localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(32768);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     sh16_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] biased;

   assign prod_in = $signed({1'b0, issue.op_a}) * $signed(issue.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh16_ff <= issue.shift16;
   end

   // round half up: add half an LSB, then floor
   always_comb begin
      if (sh16_ff) begin
         biased = prod_ff + HALF16;
         rnd    = biased >>> 16;
      end else begin
         biased = prod_ff + HALF8;
         rnd    = biased >>> FRAC_W;
      end
      result = acc + rnd[VAL_W-1:0];
   end

endmodule

### rtl/spd_store.sv
// One channel's delay store: single write port, single registered read port.
// Uses spd_pkg for depth and sample width.
module spd_store import spd_pkg::*; (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/stereo_ping_pong_delay.sv
// Top level of the stereo ping-pong delay: sequencer, registers, two stores.
// Depends on spd_pkg, spd_req_if, spd_rsp_if, spd_mul and spd_store.
//
//   channel   | direction | handshake       | payload
//   ----------+-----------+-----------------+-------------------------------
//   req_if    | in        | valid / ready   | left_in, right_in   (s24 each)
//   rsp_if    | out       | valid / ready   | left_out, right_out (s24 each)
//   csr_*     | in        | csr_we only     | csr_index, csr_wdata (24 bits)
//
// A normal transaction keeps req_if.ready low from the accept through states
// RD1, RD2, M3 to M9 and DONE, so the next one is taken only once the last is
// through: the eight multiplies issue one per cycle through the single shared
// multiplier from the first read step on, the last registered product is
// collected in M9, and DONE loads the output register. Each store read port
// fetches the older interpolation neighbor in the accept cycle and the newer
// one next. When the read slot equals the write slot the transaction bypasses
// the datapath: it goes from the accept straight to DONE, with ready low there.
// After reset both stores are cleared one entry per cycle, STORE_DEPTH entries
// (65536), with req_if.ready low; configuration writes are taken throughout.
// The result sits in an output register; a stalled rsp_if holds the sequencer
// in its last state but does not lose anything.
module stereo_ping_pong_delay import spd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   spd_req_if.sink               req_if,
   spd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD1   = 4'd2;
   localparam logic [3:0] S_RD2   = 4'd3;
   localparam logic [3:0] S_M3    = 4'd4;
   localparam logic [3:0] S_M4    = 4'd5;
   localparam logic [3:0] S_M5    = 4'd6;
   localparam logic [3:0] S_M6    = 4'd7;
   localparam logic [3:0] S_M7    = 4'd8;
   localparam logic [3:0] S_M8    = 4'd9;
   localparam logic [3:0] S_M9    = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   // Control registers
   logic [3:0]        state_ff,    state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0] wi_ff,       wi_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [BAL_W-1:0] balance_ff;
   logic [DLY_W-1:0] delay_ff;
   logic [FB_W-1:0]  feedback_ff;
   logic [MIX_W-1:0] mix_ff;

   // Datapath registers
   logic [ADDR_W-1:0]       rn_ff,    rn_in;
   logic [FRAC_W-1:0]       frac_ff,  frac_in;
   logic signed [VAL_W-1:0] raw_l_ff, raw_l_in;
   logic signed [VAL_W-1:0] raw_r_ff, raw_r_in;
   logic signed [VAL_W-1:0] a_l_ff,   a_l_in;
   logic signed [VAL_W-1:0] a_r_ff,   a_r_in;
   logic signed [VAL_W-1:0] dif_l_ff, dif_l_in;
   logic signed [VAL_W-1:0] dif_r_ff, dif_r_in;
   logic signed [VAL_W-1:0] wl_ff,    wl_in;
   logic signed [VAL_W-1:0] wr_ff,    wr_in;
   logic signed [VAL_W-1:0] dl_ff,    dl_in;
   logic signed [VAL_W-1:0] dr_ff,    dr_in;
   logic signed [VAL_W-1:0] fl_ff,    fl_in;
   logic signed [VAL_W-1:0] fr_ff,    fr_in;
   logic signed [VAL_W-1:0] yl_ff,    yl_in;
   logic signed [VAL_W-1:0] yr_ff,    yr_in;
   logic [FIELD_W-1:0]      rsp_left_ff,  rsp_left_in;
   logic [FIELD_W-1:0]      rsp_right_ff, rsp_right_in;

   // Read position and helpers
   logic [RP_W+DLY_W-1:0]   dly_wide;
   logic [RP_W-1:0]         rp;
   logic [ADDR_W-1:0]       ri;
   logic                    accept;
   logic                    out_free;
   logic signed [VAL_W-1:0] in_l_ext, in_r_ext;
   logic signed [VAL_W-1:0] q_l_ext,  q_r_ext;

   // Store ports
   logic                   st_we;
   logic [ADDR_W-1:0]      st_waddr;
   logic [SAMPLE_BITS-1:0] st_wdata_l, st_wdata_r;
   logic [ADDR_W-1:0]      st_raddr;
   logic [SAMPLE_BITS-1:0] st_q_l, st_q_r;

   // Shared multiplier
   mul_issue_type           mul_issue;
   logic signed [VAL_W-1:0] mul_acc;
   logic signed [VAL_W-1:0] mul_res;

   spd_mul u_mul (
      .clock  (clock),
      .issue  (mul_issue),
      .acc    (mul_acc),
      .result (mul_res)
   );

   spd_store u_store_l (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata_l),
      .rd_addr (st_raddr),
      .rd_data (st_q_l)
   );

   spd_store u_store_r (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata_r),
      .rd_addr (st_raddr),
      .rd_data (st_q_r)
   );

   // Handshakes
   assign req_if.ready     = (state_ff == S_IDLE);
   assign accept           = req_if.valid && req_if.ready;
   assign out_free         = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.left_out  = rsp_left_ff;
   assign rsp_if.right_out = rsp_right_ff;

   // Read position: write index minus delay, wrapped over the whole ring
   always_comb begin
      dly_wide = {{RP_W{1'b0}}, delay_ff};
      rp       = {wi_ff, {FRAC_W{1'b0}}} - dly_wide[RP_W-1:0];
      ri       = rp[RP_W-1:FRAC_W];
   end

   assign in_l_ext = {{(VAL_W-FIELD_W){req_if.left_in[FIELD_W-1]}}, req_if.left_in};
   assign in_r_ext = {{(VAL_W-FIELD_W){req_if.right_in[FIELD_W-1]}}, req_if.right_in};
   assign q_l_ext  = {{(VAL_W-SAMPLE_BITS){st_q_l[SAMPLE_BITS-1]}}, st_q_l};
   assign q_r_ext  = {{(VAL_W-SAMPLE_BITS){st_q_r[SAMPLE_BITS-1]}}, st_q_r};

   // Fetch the older neighbor while idle, the newer one in the first read step
   assign st_raddr = (state_ff == S_RD1) ? rn_ff : ri;

   // Store writes: zero sweep after reset, feedback write once per non-bypassed transaction
   always_comb begin
      st_we      = 1'b0;
      st_waddr   = wi_ff;
      st_wdata_l = sat_sample(fl_ff);
      st_wdata_r = sat_sample(fr_ff);
      if (state_ff == S_CLEAR) begin
         st_we      = 1'b1;
         st_waddr   = clr_addr_ff;
         st_wdata_l = '0;
         st_wdata_r = '0;
      end else if (state_ff == S_M8) begin
         st_we = 1'b1;
      end
   end

   // Multiplier schedule: issue in one state, collect in the next
   always_comb begin
      mul_issue = '0;
      mul_acc   = '0;
      case (state_ff)
         S_RD1: begin
            mul_issue = '{op_a: ONE_Q16 - {1'b0, balance_ff}, op_b: raw_l_ff, shift16: 1'b1};
         end
         S_RD2: begin
            mul_issue = '{op_a: {1'b0, balance_ff}, op_b: raw_r_ff, shift16: 1'b1};
         end
         S_M3: begin
            mul_issue = '{op_a: {{(GAIN_W-FRAC_W){1'b0}}, frac_ff}, op_b: dif_l_ff,
                          shift16: 1'b0};
         end
         S_M4: begin
            mul_issue = '{op_a: {{(GAIN_W-FRAC_W){1'b0}}, frac_ff}, op_b: dif_r_ff,
                          shift16: 1'b0};
            mul_acc   = a_l_ff;
         end
         S_M5: begin
            mul_issue = '{op_a: {1'b0, feedback_ff}, op_b: dl_ff, shift16: 1'b1};
            mul_acc   = a_r_ff;
         end
         S_M6: begin
            mul_issue = '{op_a: {1'b0, feedback_ff}, op_b: dr_ff, shift16: 1'b1};
            mul_acc   = wr_ff;
         end
         S_M7: begin
            mul_issue = '{op_a: mix_ff, op_b: dif_l_ff, shift16: 1'b1};
            mul_acc   = wl_ff;
         end
         S_M8: begin
            mul_issue = '{op_a: mix_ff, op_b: dif_r_ff, shift16: 1'b1};
            mul_acc   = wl_ff;
         end
         S_M9: begin
            mul_acc = wr_ff;
         end
         default: begin
            mul_issue = '0;
            mul_acc   = '0;
         end
      endcase
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      wi_in        = wi_ff;
      rsp_valid_in = rsp_valid_ff;
      rn_in        = rn_ff;
      frac_in      = frac_ff;
      raw_l_in     = raw_l_ff;
      raw_r_in     = raw_r_ff;
      a_l_in       = a_l_ff;
      a_r_in       = a_r_ff;
      dif_l_in     = dif_l_ff;
      dif_r_in     = dif_r_ff;
      wl_in        = wl_ff;
      wr_in        = wr_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      fl_in        = fl_ff;
      fr_in        = fr_ff;
      yl_in        = yl_ff;
      yr_in        = yr_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      // drop the result once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               raw_l_in = in_l_ext;
               raw_r_in = in_r_ext;
               rn_in    = ri + ADDR_W'(1);
               frac_in  = rp[FRAC_W-1:0];
               if (ri == wi_ff) begin
                  // read slot on the write slot: pass the input straight through
                  yl_in    = in_l_ext;
                  yr_in    = in_r_ext;
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD1;
               end
            end
         end
         S_RD1: begin
            a_l_in   = q_l_ext;
            a_r_in   = q_r_ext;
            state_in = S_RD2;
         end
         S_RD2: begin
            dif_l_in = q_l_ext - a_l_ff;
            dif_r_in = q_r_ext - a_r_ff;
            wl_in    = mul_res;
            state_in = S_M3;
         end
         S_M3: begin
            wr_in    = mul_res;
            state_in = S_M4;
         end
         S_M4: begin
            dl_in    = mul_res;
            state_in = S_M5;
         end
         S_M5: begin
            dr_in    = mul_res;
            dif_l_in = dl_ff - wl_ff;
            state_in = S_M6;
         end
         S_M6: begin
            fr_in    = mul_res;
            dif_r_in = dr_ff - wr_ff;
            state_in = S_M7;
         end
         S_M7: begin
            fl_in    = mul_res;
            state_in = S_M8;
         end
         S_M8: begin
            yl_in    = mul_res;
            state_in = S_M9;
         end
         S_M9: begin
            yr_in    = mul_res;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free, then advance
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = to_field(sat_sample(yl_ff));
               rsp_right_in = to_field(sat_sample(yr_ff));
               wi_in        = wi_ff + ADDR_W'(1);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         wi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wi_ff        <= wi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rn_ff        <= rn_in;
      frac_ff      <= frac_in;
      raw_l_ff     <= raw_l_in;
      raw_r_ff     <= raw_r_in;
      a_l_ff       <= a_l_in;
      a_r_ff       <= a_r_in;
      dif_l_ff     <= dif_l_in;
      dif_r_ff     <= dif_r_in;
      wl_ff        <= wl_in;
      wr_ff        <= wr_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      fl_ff        <= fl_in;
      fr_ff        <= fr_in;
      yl_ff        <= yl_in;
      yr_ff        <= yr_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         balance_ff  <= BAL_RESET;
         delay_ff    <= DLY_RESET;
         feedback_ff <= FB_RESET;
         mix_ff      <= MIX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BALANCE:  balance_ff  <= csr_wdata[BAL_W-1:0];
            CSR_DELAY:    delay_ff    <= csr_wdata[DLY_W-1:0];
            CSR_FEEDBACK: feedback_ff <= csr_wdata[FB_W-1:0];
            CSR_MIX:      mix_ff      <= csr_wdata[MIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after accepting a transaction");

   a_wi_advances_on_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> wi_ff == $past(wi_ff) + ADDR_W'(1))
      else $error("write index did not advance with the result");

   a_wi_holds_otherwise: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_DONE && out_free) |=> $stable(wi_ff))
      else $error("write index moved without a result");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_if.ready)
      else $error("input ready during the store clearing pass");
`endif

endmodule
